// File: rtl/art_pkg.sv
// Shared types, codes and constants of the ack retransmit tracker.
// Used by art_mem, art_seq and ack_retransmit_tracker_core; depends on nothing.
package art_pkg;

    // Field widths of the stream items.
    localparam int unsigned ID_W     = 32;
    localparam int unsigned AGE_W    = 16;
    localparam int unsigned RETRY_W  = 4;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned EVENT_W  = 3;

    // Default number of table entries.
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Saturation value of an entry's age.
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Configuration register indexes and reset values.
    localparam int unsigned      CFG_IDX_W         = 1;
    localparam int unsigned      CFG_DATA_W        = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b1;
    localparam logic [AGE_W-1:0]   ACK_TIMEOUT_RST = 16'd2;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

    // Input action codes.
    localparam logic [ACTION_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

    // Result event codes.
    localparam logic [EVENT_W-1:0] EV_STORED  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_FULL    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ACKED   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_UNKNOWN = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RESEND  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_GIVEUP  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd6;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [AGE_W-1:0]   age;
        logic [RETRY_W-1:0] retries;
    } t_entry;

    // One result item.
    typedef struct packed {
        logic               last;
        logic [EVENT_W-1:0] res;
        logic [ID_W-1:0]    id;
        logic [RETRY_W-1:0] retries;
    } t_result;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

// File: rtl/ack_retransmit_tracker_core.sv
// Top level of the ack retransmit tracker: configuration registers, output register,
// entry memory and sequencer. Depends on art_pkg, art_mem and art_seq.
//
// Channel   Dir  Beat fields
// s (in)    in   tuser[1:0] action; tdata[31:0] msg_id
// m (out)   out  tuser[2:0] event_res; tdata[31:0] event_id, [35:32] retry_count; tlast
// cfg       in   i_cfg_index register (0 ack_timeout, 1 retry_limit); i_cfg_data value
//
// Send, ack and tick items run in steps from one accepted beat to the next: the single read
// port scans one entry per cycle while the scan is not held, a further step evaluates the
// last read data, the final step writes a send's slot and emits the final beat, and the idle
// state takes the next beat. Items with an unused action code skip the scan. A full output register holds
// the scan when a tick finds another due entry, and holds the final cycle of every item.
// Reset clears the valid bits at once; no clearing pass runs. Config writes are taken
// in every cycle.
module ack_retransmit_tracker_core #(
    parameter int unsigned TABLE_DEPTH = art_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [31:0]                      i_s_tdata,   // [31:0] msg_id
    input  logic [1:0]                       i_s_tuser,   // [1:0] action
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [39:0]                      o_m_tdata,   // [31:0] event_id, [35:32] retry_count
    output logic [2:0]                       o_m_tuser,   // [2:0] event_res
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [art_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    logic [art_pkg::AGE_W-1:0]   r_ack_timeout;
    logic [art_pkg::RETRY_W-1:0] r_retry_limit;
    logic                        r_out_valid;
    art_pkg::t_result            r_out;

    logic                        idle;
    logic                        can_emit;
    art_pkg::t_push              push;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    art_pkg::t_entry             mem_wdata;
    logic                        mem_re;
    logic [IDX_W-1:0]            mem_raddr;
    art_pkg::t_entry             mem_rdata;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= art_pkg::ACK_TIMEOUT_RST;
            r_retry_limit <= art_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                art_pkg::CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                art_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[art_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register; it takes a new beat when empty or being drained.
    assign can_emit = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out <= push.data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.retries, r_out.id};
    assign o_m_tuser  = r_out.res;
    assign o_m_tlast  = r_out.last;
    assign o_s_tready = idle;

    art_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    art_seq #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_s_tvalid && idle),
        .i_action      (i_s_tuser),
        .i_msg_id      (i_s_tdata),
        .i_ack_timeout (r_ack_timeout),
        .i_retry_limit (r_retry_limit),
        .i_can_emit    (can_emit),
        .o_idle        (idle),
        .o_push        (push),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

endmodule

// File: rtl/art_mem.sv
// Entry memory of the tracker: one write port, one read port, registered read data.
// Depends on art_pkg for the entry type.
module art_mem #(
    parameter int unsigned DEPTH = art_pkg::DEPTH_DEFAULT,
    parameter int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  art_pkg::t_entry   i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output art_pkg::t_entry   o_rdata
);

    art_pkg::t_entry r_mem [DEPTH];
    art_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/art_seq.sv
// Sequencer of the tracker: scans the entry memory once per send, ack or tick item, holds
// the valid bits, updates entries and produces result beats. Depends on art_pkg.
module art_seq #(
    parameter int unsigned DEPTH = art_pkg::DEPTH_DEFAULT,
    parameter int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [art_pkg::ACTION_W-1:0]  i_action,
    input  logic [art_pkg::ID_W-1:0]      i_msg_id,
    input  logic [art_pkg::AGE_W-1:0]     i_ack_timeout,
    input  logic [art_pkg::RETRY_W-1:0]   i_retry_limit,
    input  logic                          i_can_emit,
    output logic                          o_idle,
    output art_pkg::t_push                o_push,
    output logic                          o_mem_we,
    output logic [IDX_W-1:0]              o_mem_waddr,
    output art_pkg::t_entry               o_mem_wdata,
    output logic                          o_mem_re,
    output logic [IDX_W-1:0]              o_mem_raddr,
    input  art_pkg::t_entry               i_mem_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [IDX_W:0] CNT_END = (IDX_W+1)'(DEPTH);

    logic [1:0]                       r_state;
    logic [art_pkg::ACTION_W-1:0]     r_action;
    logic [art_pkg::ID_W-1:0]         r_id;
    logic [IDX_W:0]                   r_rd_cnt;
    logic                             r_ev_valid;
    logic [IDX_W-1:0]                 r_ev_idx;
    logic [DEPTH-1:0]                 r_valid;
    logic                             r_match_found;
    logic [IDX_W-1:0]                 r_match_idx;
    logic                             r_free_found;
    logic [IDX_W-1:0]                 r_free_idx;
    logic                             r_pend_valid;
    art_pkg::t_result                 r_pend;

    logic                             is_tick;
    logic                             ev_entry;
    logic                             ev_tick;
    logic [art_pkg::AGE_W-1:0]        age_inc;
    logic                             due;
    logic                             can_retry;
    logic                             res_new;
    logic                             stall;
    logic                             advance;
    logic                             rd_more;
    logic                             fin_go;
    art_pkg::t_result                 new_res;
    art_pkg::t_result                 fin_res;
    logic [IDX_W-1:0]                 slot_idx;
    logic                             slot_ok;

    // Evaluation of the entry whose read data is present.
    always_comb begin
        is_tick   = (r_action == art_pkg::ACT_TICK);
        ev_entry  = (r_state == ST_SCAN) && r_ev_valid && r_valid[r_ev_idx];
        ev_tick   = ev_entry && is_tick;
        age_inc   = (i_mem_rdata.age != art_pkg::AGE_MAX) ? i_mem_rdata.age + 16'd1
                                                          : i_mem_rdata.age;
        due       = (age_inc >= i_ack_timeout);
        can_retry = (i_mem_rdata.retries < i_retry_limit);
        res_new   = ev_tick && due;
        stall     = res_new && r_pend_valid && !i_can_emit;
        advance   = (r_state == ST_SCAN) && !stall;
        rd_more   = (r_rd_cnt != CNT_END);
        fin_go    = (r_state == ST_FIN) && i_can_emit;

        new_res.last    = 1'b0;
        new_res.id      = i_mem_rdata.id;
        new_res.res     = can_retry ? art_pkg::EV_RESEND : art_pkg::EV_GIVEUP;
        new_res.retries = can_retry ? i_mem_rdata.retries + 4'd1 : '0;
    end

    // Slot for a send: the matching entry, else the lowest free one.
    assign slot_ok  = r_match_found || r_free_found;
    assign slot_idx = r_match_found ? r_match_idx : r_free_idx;

    // Final result of the item.
    always_comb begin
        fin_res = '0;
        fin_res.last = 1'b1;
        unique case (r_action)
            art_pkg::ACT_SEND: begin
                fin_res.res = slot_ok ? art_pkg::EV_STORED : art_pkg::EV_FULL;
                fin_res.id  = r_id;
            end
            art_pkg::ACT_ACK: begin
                fin_res.res = r_match_found ? art_pkg::EV_ACKED : art_pkg::EV_UNKNOWN;
                fin_res.id  = r_id;
            end
            art_pkg::ACT_TICK: begin
                if (r_pend_valid) begin
                    fin_res      = r_pend;
                    fin_res.last = 1'b1;
                end else begin
                    fin_res.res = art_pkg::EV_NONE;
                end
            end
            default: begin
                fin_res.res = art_pkg::EV_NONE;
            end
        endcase
    end

    // Result beats toward the output register.
    always_comb begin
        o_push = '0;
        if (fin_go) begin
            o_push.valid = 1'b1;
            o_push.data  = fin_res;
        end else if (advance && res_new && r_pend_valid) begin
            o_push.valid = 1'b1;
            o_push.data  = r_pend;
        end
    end

    // Memory port control.
    always_comb begin
        o_mem_re    = advance && rd_more;
        o_mem_raddr = r_rd_cnt[IDX_W-1:0];
        if (r_state == ST_FIN) begin
            o_mem_we    = fin_go && (r_action == art_pkg::ACT_SEND) && slot_ok;
            o_mem_waddr = slot_idx;
            o_mem_wdata.id      = r_id;
            o_mem_wdata.age     = '0;
            o_mem_wdata.retries = '0;
        end else begin
            o_mem_we    = advance && ev_tick;
            o_mem_waddr = r_ev_idx;
            o_mem_wdata.id      = i_mem_rdata.id;
            o_mem_wdata.age     = (due && can_retry) ? '0 : age_inc;
            o_mem_wdata.retries = (due && can_retry) ? i_mem_rdata.retries + 4'd1
                                                     : i_mem_rdata.retries;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

    // Sequencer state, scan pointers, valid bits and the held result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rd_cnt      <= '0;
            r_ev_valid    <= 1'b0;
            r_valid       <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_pend_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_action      <= i_action;
                        r_id          <= i_msg_id;
                        r_rd_cnt      <= '0;
                        r_ev_valid    <= 1'b0;
                        r_match_found <= 1'b0;
                        r_free_found  <= 1'b0;
                        r_pend_valid  <= 1'b0;
                        if (i_action == art_pkg::ACT_SEND || i_action == art_pkg::ACT_ACK ||
                            i_action == art_pkg::ACT_TICK) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        // Issue the next read, or finish after the last entry.
                        if (rd_more) begin
                            r_ev_valid <= 1'b1;
                            r_ev_idx   <= r_rd_cnt[IDX_W-1:0];
                            r_rd_cnt   <= r_rd_cnt + 1'b1;
                        end else begin
                            r_ev_valid <= 1'b0;
                            r_state    <= ST_FIN;
                        end
                        // Search for the id and the first free slot.
                        if (r_ev_valid && !is_tick) begin
                            if (r_valid[r_ev_idx] && i_mem_rdata.id == r_id &&
                                !r_match_found) begin
                                r_match_found <= 1'b1;
                                r_match_idx   <= r_ev_idx;
                            end
                            if (!r_valid[r_ev_idx] && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_ev_idx;
                            end
                        end
                        // A due entry becomes the held result.
                        if (res_new) begin
                            r_pend_valid <= 1'b1;
                            r_pend       <= new_res;
                            if (!can_retry) begin
                                r_valid[r_ev_idx] <= 1'b0;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    if (i_can_emit) begin
                        if (r_action == art_pkg::ACT_SEND && slot_ok) begin
                            r_valid[slot_idx] <= 1'b1;
                        end
                        if (r_action == art_pkg::ACT_ACK && r_match_found) begin
                            r_valid[r_match_idx] <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // A beat is only handed over when the output register can take it.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_can_emit)
        else $error("result pushed while output register is full");

    // Nothing is produced while no item is in work.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!o_push.valid && !o_mem_we))
        else $error("activity while idle");

    // The final beat of an item returns the sequencer to idle.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.data.last) |=> (r_state == ST_IDLE))
        else $error("item did not end after its last beat");

    // The read pointer never runs past the table.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= CNT_END)
        else $error("scan pointer beyond table depth");
`endif

endmodule
